// File: rtl/core/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types, constants and helpers of the ring polynomial inverse block.
// ----------------------------------------------------------------------------
package rpi_pkg;

	localparam int COEFFS     = 256;
	localparam int WORK_DEPTH = 512;
	localparam int CW         = 23;
	localparam int IDXW       = 8;
	localparam int LEN        = COEFFS + 1;
	localparam int WIDX       = $clog2(WORK_DEPTH);
	localparam int RGW        = 3;
	localparam int AW         = RGW + WIDX;
	localparam int MEM_DEPTH  = 1 << AW;
	localparam bit WORK_OK    = (WORK_DEPTH >= LEN);

	localparam logic [CW-1:0] MODULUS_RESET = 23'd8380417;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// regions of the shared work memory
	typedef enum logic [RGW-1:0] {
		RG_REM0, RG_REM1, RG_COF0, RG_COF1, RG_QUOT, RG_INP, RG_INV
	} region_t;

	typedef enum logic {AOP_MUL, AOP_DIV} aop_t;

	typedef struct packed {
		logic          start;
		aop_t          op;
		logic [CW-1:0] a;
		logic [CW-1:0] b;
		logic [CW-1:0] m;
	} arith_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [CW-1:0] res;
		logic [CW-1:0] quo;
	} arith_rsp_t;

	typedef struct packed {
		logic [1:0]      command;
		logic [IDXW-1:0] index;
		logic [CW-1:0]   coefficient;
	} req_t;

	typedef struct packed {
		logic [CW-1:0] data;
		logic          invertible;
		logic          is_status;
	} rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_RDATA, ST_START,
		ST_INIT_RD, ST_INIT_RED, ST_INIT_WAIT, ST_INIT_WR,
		ST_LOOP_HEAD, ST_LEAD,
		ST_INV_TEST, ST_INV_DIV, ST_INV_MUL, ST_INV_MWAIT, ST_INV_END,
		ST_QCLR,
		ST_DV_RD, ST_DV_C, ST_DV_CWAIT, ST_DV_QWR, ST_DV_RA, ST_DV_RB, ST_DV_RC,
		ST_DV_MWAIT, ST_DV_WR, ST_DV_NEXT,
		ST_RS_START, ST_RS_RD, ST_RS_CHK,
		ST_CF_RD, ST_CF_Q, ST_CF_RA, ST_CF_RB, ST_CF_RC, ST_CF_MWAIT, ST_CF_WR,
		ST_CF_JNEXT, ST_CF_NEXT,
		ST_SWAP, ST_FIN_CHK, ST_FIN_G,
		ST_SC_RD, ST_SC_M, ST_SC_WAIT, ST_SC_WR,
		ST_FAIL, ST_DONE
	} st_t;

	// x - p modulo m, both operands already reduced
	function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] x, input logic [CW-1:0] p,
		input logic [CW-1:0] m);
		logic [CW:0] t;
		t = {1'b0, x} - {1'b0, p};
		if (x < p) begin
			t = t + {1'b0, m};
		end
		return t[CW-1:0];
	endfunction

endpackage

// File: rtl/core/ring_polynomial_inverse.sv
// ----------------------------------------------------------------------------
// ring_polynomial_inverse
// Inverse of a polynomial in Zq[x]/(x^N+1) by extended Euclid over one work
// memory and one bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// write item: written to memory when taken, no result
// read item: result passes the RAM read register and the output register; no new item is taken until it is loaded
// start item: runs as coefficient products on the shared bit-serial unit plus memory
//   port steps; on the order of N^2 products
// reset clears control and flag and sets the modulus to 8380417; memories are not cleared
// ----------------------------------------------------------------------------
module ring_polynomial_inverse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [rpi_pkg::CW-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  rpi_pkg::req_t         req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rpi_pkg::rsp_t         rsp
);
	import rpi_pkg::*;

	localparam logic [WIDX-1:0] LAST = WIDX'(LEN - 1);

	st_t             state_q, state_d;
	logic [CW-1:0]   modulus_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	logic            ok_q, sel_q, cur_zero_q, nzero_q, ret_gcd_q, rd_ok_q;
	logic [WIDX-1:0] i_q, j_q, d_q, k_q, db_q, dold_q, ndeg_q, cdeg_old_q, cdeg_cur_q;
	logic [1:0]      sub_q;
	logic [CW-1:0]   u_q, c_q, x_q, r0_q, r1_q, t0_q, t1_q, qv_q;

	logic            accept, idx_ok;
	region_t         rem_old_rg, rem_cur_rg, cof_old_rg, cof_cur_rg;
	logic [WIDX-1:0] qdeg, dv_idx, capped, newbound;
	logic [WIDX:0]   ij, bsum;
	logic [CW-1:0]   x_in;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [CW-1:0]   mem_wdata, mem_rdata;
	arith_req_t      areq;
	arith_rsp_t      arsp;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign idx_ok     = (int'(req.index) < COEFFS);
	assign rem_old_rg = sel_q ? RG_REM1 : RG_REM0;
	assign rem_cur_rg = sel_q ? RG_REM0 : RG_REM1;
	assign cof_old_rg = sel_q ? RG_COF1 : RG_COF0;
	assign cof_cur_rg = sel_q ? RG_COF0 : RG_COF1;
	assign qdeg       = dold_q - db_q;
	assign dv_idx     = d_q - db_q + j_q;
	assign ij         = {1'b0, i_q} + {1'b0, j_q};
	assign x_in       = ({1'b0, i_q} < (WIDX+1)'(COEFFS)) ? mem_rdata : '0;
	// bound on the degree of the updated cofactor
	assign bsum       = {1'b0, qdeg} + {1'b0, cdeg_cur_q};
	assign capped     = (bsum > (WIDX+1)'(LEN - 1)) ? LAST : bsum[WIDX-1:0];
	assign newbound   = (capped > cdeg_old_q) ? capped : cdeg_old_q;

	rpi_ram #(.WIDTH(CW), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rpi_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.command)
						CMD_START: state_d = ST_START;
						CMD_READ:  state_d = ST_RDATA;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RDATA:     state_d = ST_IDLE;
			ST_START:     state_d = (modulus_q < CW'(2) || !WORK_OK) ? ST_FAIL : ST_INIT_RD;
			ST_INIT_RD:   state_d = ST_INIT_RED;
			ST_INIT_RED:  state_d = ST_INIT_WAIT;
			ST_INIT_WAIT: state_d = arsp.done ? ST_INIT_WR : ST_INIT_WAIT;
			ST_INIT_WR: begin
				if (sub_q == 2'd3) begin
					state_d = (i_q == LAST) ? ST_LOOP_HEAD : ST_INIT_RD;
				end
			end
			ST_LOOP_HEAD: state_d = cur_zero_q ? ST_FIN_CHK : ST_LEAD;
			ST_LEAD:      state_d = ST_INV_TEST;
			ST_INV_TEST:  state_d = (r1_q == '0) ? ST_INV_END : ST_INV_DIV;
			ST_INV_DIV:   state_d = arsp.done ? ST_INV_MUL : ST_INV_DIV;
			ST_INV_MUL:   state_d = ST_INV_MWAIT;
			ST_INV_MWAIT: state_d = arsp.done ? ST_INV_TEST : ST_INV_MWAIT;
			ST_INV_END: begin
				if (r0_q != CW'(1)) begin
					state_d = ST_FAIL;
				end else begin
					state_d = ret_gcd_q ? ST_SC_RD : ST_QCLR;
				end
			end
			ST_QCLR:      state_d = (i_q == LAST) ? ST_DV_RD : ST_QCLR;
			ST_DV_RD:     state_d = ST_DV_C;
			ST_DV_C:      state_d = (mem_rdata == '0) ? ST_DV_NEXT : ST_DV_CWAIT;
			ST_DV_CWAIT:  state_d = arsp.done ? ST_DV_QWR : ST_DV_CWAIT;
			ST_DV_QWR:    state_d = ST_DV_RA;
			ST_DV_RA:     state_d = ST_DV_RB;
			ST_DV_RB:     state_d = ST_DV_RC;
			ST_DV_RC:     state_d = ST_DV_MWAIT;
			ST_DV_MWAIT:  state_d = arsp.done ? ST_DV_WR : ST_DV_MWAIT;
			ST_DV_WR:     state_d = (j_q == db_q) ? ST_DV_NEXT : ST_DV_RA;
			ST_DV_NEXT:   state_d = (d_q == db_q) ? ST_RS_START : ST_DV_RD;
			ST_RS_START:  state_d = (db_q == '0) ? ST_CF_RD : ST_RS_RD;
			ST_RS_RD:     state_d = ST_RS_CHK;
			ST_RS_CHK: begin
				if (mem_rdata != '0 || k_q == '0) begin
					state_d = ST_CF_RD;
				end else begin
					state_d = ST_RS_RD;
				end
			end
			ST_CF_RD:     state_d = ST_CF_Q;
			ST_CF_Q:      state_d = (mem_rdata == '0) ? ST_CF_NEXT : ST_CF_RA;
			ST_CF_RA:     state_d = ST_CF_RB;
			ST_CF_RB:     state_d = (mem_rdata == '0) ? ST_CF_JNEXT : ST_CF_RC;
			ST_CF_RC:     state_d = ST_CF_MWAIT;
			ST_CF_MWAIT:  state_d = arsp.done ? ST_CF_WR : ST_CF_MWAIT;
			ST_CF_WR:     state_d = ST_CF_JNEXT;
			ST_CF_JNEXT: begin
				if (j_q == cdeg_cur_q || ij == (WIDX+1)'(LEN - 1)) begin
					state_d = ST_CF_NEXT;
				end else begin
					state_d = ST_CF_RA;
				end
			end
			ST_CF_NEXT:   state_d = (i_q == qdeg) ? ST_SWAP : ST_CF_RD;
			ST_SWAP:      state_d = ST_LOOP_HEAD;
			ST_FIN_CHK:   state_d = (dold_q != '0) ? ST_FAIL : ST_FIN_G;
			ST_FIN_G:     state_d = ST_INV_TEST;
			ST_SC_RD:     state_d = ST_SC_M;
			ST_SC_M:      state_d = ST_SC_WAIT;
			ST_SC_WAIT:   state_d = arsp.done ? ST_SC_WR : ST_SC_WAIT;
			ST_SC_WR:     state_d = (i_q == WIDX'(COEFFS - 1)) ? ST_DONE : ST_SC_RD;
			ST_FAIL:      state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory port and shared unit control
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = {RG_QUOT, i_q};
		mem_wdata  = '0;
		mem_raddr  = {RG_INV, WIDX'(req.index)};
		areq.start = 1'b0;
		areq.op    = AOP_MUL;
		areq.a     = '0;
		areq.b     = '0;
		areq.m     = modulus_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.command == CMD_WRITE && idx_ok) begin
					mem_we    = 1'b1;
					mem_waddr = {RG_INP, WIDX'(req.index)};
					mem_wdata = req.coefficient;
				end
			end
			ST_INIT_RD: mem_raddr = {RG_INP, i_q};
			ST_INIT_RED: begin
				// reduction of the input coefficient as 1 * x mod m
				areq.start = 1'b1;
				areq.a     = CW'(1);
				areq.b     = x_in;
			end
			ST_INIT_WR: begin
				mem_we = 1'b1;
				case (sub_q)
					2'd0: begin
						mem_waddr = {rem_old_rg, i_q};
						mem_wdata = (i_q == '0 || i_q == WIDX'(COEFFS)) ? CW'(1) : '0;
					end
					2'd1: begin
						mem_waddr = {rem_cur_rg, i_q};
						mem_wdata = x_q;
					end
					2'd2: begin
						mem_waddr = {cof_old_rg, i_q};
						mem_wdata = '0;
					end
					default: begin
						mem_waddr = {cof_cur_rg, i_q};
						mem_wdata = (i_q == '0) ? CW'(1) : '0;
					end
				endcase
			end
			ST_LOOP_HEAD: mem_raddr = {rem_cur_rg, db_q};
			ST_INV_TEST: begin
				if (r1_q != '0) begin
					areq.start = 1'b1;
					areq.op    = AOP_DIV;
					areq.a     = r0_q;
					areq.b     = r1_q;
				end
			end
			ST_INV_MUL: begin
				areq.start = 1'b1;
				areq.a     = t1_q;
				areq.b     = qv_q;
			end
			ST_QCLR: begin
				mem_we    = 1'b1;
				mem_waddr = {RG_QUOT, i_q};
			end
			ST_DV_RD: mem_raddr = {rem_old_rg, d_q};
			ST_DV_C: begin
				if (mem_rdata != '0) begin
					areq.start = 1'b1;
					areq.a     = mem_rdata;
					areq.b     = u_q;
				end
			end
			ST_DV_QWR: begin
				mem_we    = 1'b1;
				mem_waddr = {RG_QUOT, qdeg - (dold_q - d_q)};
				mem_wdata = c_q;
			end
			ST_DV_RA: mem_raddr = {rem_cur_rg, j_q};
			ST_DV_RB: begin
				areq.start = 1'b1;
				areq.a     = c_q;
				areq.b     = mem_rdata;
				mem_raddr  = {rem_old_rg, dv_idx};
			end
			ST_DV_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {rem_old_rg, dv_idx};
				mem_wdata = sub_mod(x_q, arsp.res, modulus_q);
			end
			ST_RS_RD: mem_raddr = {rem_old_rg, k_q};
			ST_CF_RD: mem_raddr = {RG_QUOT, i_q};
			ST_CF_RA: mem_raddr = {cof_cur_rg, j_q};
			ST_CF_RB: begin
				if (mem_rdata != '0) begin
					areq.start = 1'b1;
					areq.a     = c_q;
					areq.b     = mem_rdata;
				end
				mem_raddr = {cof_old_rg, ij[WIDX-1:0]};
			end
			ST_CF_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {cof_old_rg, ij[WIDX-1:0]};
				mem_wdata = sub_mod(x_q, arsp.res, modulus_q);
			end
			ST_FIN_CHK: mem_raddr = {rem_old_rg, WIDX'(0)};
			ST_SC_RD:   mem_raddr = {cof_old_rg, i_q};
			ST_SC_M: begin
				areq.start = 1'b1;
				areq.a     = mem_rdata;
				areq.b     = u_q;
			end
			ST_SC_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {RG_INV, i_q};
				mem_wdata = arsp.res;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= MODULUS_RESET;
			rsp_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			sel_q       <= 1'b0;
			cur_zero_q  <= 1'b1;
			nzero_q     <= 1'b1;
			ret_gcd_q   <= 1'b0;
			rd_ok_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			d_q         <= '0;
			k_q         <= '0;
			db_q        <= '0;
			dold_q      <= '0;
			ndeg_q      <= '0;
			cdeg_old_q  <= '0;
			cdeg_cur_q  <= '0;
			sub_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				modulus_q <= cfg_data;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ok_q <= idx_ok;
					end
				end
				ST_RDATA: rsp_valid_q <= 1'b1;
				ST_START: begin
					i_q        <= '0;
					sub_q      <= '0;
					sel_q      <= 1'b0;
					cur_zero_q <= 1'b1;
					db_q       <= '0;
					ok_q       <= 1'b0;
					dold_q     <= WIDX'(COEFFS);
					cdeg_old_q <= '0;
					cdeg_cur_q <= '0;
				end
				ST_INIT_WR: begin
					sub_q <= sub_q + 1'b1;
					if (x_q != '0) begin
						db_q       <= i_q;
						cur_zero_q <= 1'b0;
					end
					if (sub_q == 2'd3) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_LEAD:    ret_gcd_q <= 1'b0;
				ST_FIN_G:   ret_gcd_q <= 1'b1;
				ST_INV_END: begin
					i_q <= '0;
					d_q <= dold_q;
				end
				ST_QCLR:    i_q <= i_q + 1'b1;
				ST_DV_QWR:  j_q <= '0;
				ST_DV_WR:   j_q <= j_q + 1'b1;
				ST_DV_NEXT: d_q <= d_q - 1'b1;
				ST_RS_START: begin
					nzero_q <= 1'b1;
					k_q     <= db_q - 1'b1;
					i_q     <= '0;
				end
				ST_RS_CHK: begin
					if (mem_rdata != '0) begin
						nzero_q <= 1'b0;
						ndeg_q  <= k_q;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_CF_Q:     j_q <= '0;
				ST_CF_JNEXT: j_q <= j_q + 1'b1;
				ST_CF_NEXT:  i_q <= i_q + 1'b1;
				ST_SWAP: begin
					sel_q      <= ~sel_q;
					dold_q     <= db_q;
					db_q       <= ndeg_q;
					cur_zero_q <= nzero_q;
					cdeg_old_q <= cdeg_cur_q;
					cdeg_cur_q <= newbound;
				end
				ST_SC_WR: begin
					i_q <= i_q + 1'b1;
					if (i_q == WIDX'(COEFFS - 1)) begin
						ok_q <= 1'b1;
					end
				end
				ST_DONE: rsp_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// response register, values of the integer inverse and the polynomial steps
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RDATA: begin
				rsp_q.data       <= (rd_ok_q && ok_q) ? mem_rdata : '0;
				rsp_q.invertible <= ok_q;
				rsp_q.is_status  <= 1'b0;
			end
			ST_DONE: begin
				rsp_q.data       <= '0;
				rsp_q.invertible <= ok_q;
				rsp_q.is_status  <= 1'b1;
			end
			ST_INIT_WAIT: begin
				if (arsp.done) begin
					x_q <= arsp.res;
				end
			end
			ST_LEAD, ST_FIN_G: begin
				r0_q <= modulus_q;
				r1_q <= mem_rdata;
				t0_q <= '0;
				t1_q <= CW'(1);
			end
			ST_INV_DIV: begin
				if (arsp.done) begin
					qv_q <= arsp.quo;
					r0_q <= r1_q;
					r1_q <= arsp.res;
				end
			end
			ST_INV_MWAIT: begin
				if (arsp.done) begin
					t0_q <= t1_q;
					t1_q <= sub_mod(t0_q, arsp.res, modulus_q);
				end
			end
			ST_INV_END: u_q <= t0_q;
			ST_DV_CWAIT: begin
				if (arsp.done) begin
					c_q <= arsp.res;
				end
			end
			ST_DV_RC, ST_CF_RC: x_q <= mem_rdata;
			ST_CF_Q: c_q <= mem_rdata;
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		areq.start |-> !arsp.busy)
		else $error("shared unit started while busy");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDATA || state_q == ST_DONE) |-> !rsp_valid_q)
		else $error("output register loaded while full");

	a_ok_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ok_q) |-> $past(state_q) == ST_SC_WR)
		else $error("invertible flag set outside final scaling");

endmodule

// File: rtl/core/rpi_ram.sv
// ----------------------------------------------------------------------------
// rpi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rpi_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/rpi_arith.sv
// ----------------------------------------------------------------------------
// rpi_arith
// Bit-serial shared unit: modular multiply (a*b mod m, a < m) or unsigned
// divide (a / b, a % b), one bit per cycle.
// ----------------------------------------------------------------------------
module rpi_arith (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rpi_pkg::arith_req_t    req,
	output rpi_pkg::arith_rsp_t    rsp
);
	import rpi_pkg::*;

	localparam int CNTW = $clog2(CW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	aop_t            op_q;
	logic [CW-1:0]   opnd_q;
	logic [CW-1:0]   shreg_q;
	logic [CW-1:0]   m_q;
	logic [CW-1:0]   acc_q;
	logic [CW:0]     t0, t1, t2;
	logic [CW-1:0]   acc_d;
	logic [CW-1:0]   shreg_d;

	always_comb begin
		t0      = '0;
		t1      = '0;
		t2      = '0;
		acc_d   = acc_q;
		shreg_d = {shreg_q[CW-2:0], 1'b0};
		if (op_q == AOP_MUL) begin
			// double, reduce, add next multiplier bit, reduce
			t0 = {acc_q, 1'b0};
			t1 = (t0 >= {1'b0, m_q}) ? t0 - {1'b0, m_q} : t0;
			t2 = shreg_q[CW-1] ? t1 + {1'b0, opnd_q} : t1;
			if (t2 >= {1'b0, m_q}) begin
				t2 = t2 - {1'b0, m_q};
			end
			acc_d = t2[CW-1:0];
		end else begin
			// restoring division, quotient bits shift in where dividend leaves
			t0 = {acc_q, shreg_q[CW-1]};
			if (t0 >= {1'b0, opnd_q}) begin
				t1         = t0 - {1'b0, opnd_q};
				shreg_d[0] = 1'b1;
			end else begin
				t1 = t0;
			end
			acc_d = t1[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(CW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q    <= req.op;
			opnd_q  <= (req.op == AOP_MUL) ? req.a : req.b;
			shreg_q <= (req.op == AOP_MUL) ? req.b : req.a;
			m_q     <= req.m;
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q   <= acc_d;
			shreg_q <= shreg_d;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = acc_q;
	assign rsp.quo  = shreg_q;

endmodule
